FILE: rtl/core/tpc_pkg.sv
`timescale 1ns / 1ps

package tpc_pkg;

  // Number of colors in the palette ROM; an index at or above this disables colorizing.
  localparam int unsigned PALETTE_ENTRIES = 133;

  // Configuration register indexes.
  localparam logic [2:0] CFG_HEAD = 3'd0;
  localparam logic [2:0] CFG_BODY = 3'd1;
  localparam logic [2:0] CFG_LEGS = 3'd2;
  localparam logic [2:0] CFG_FEET = 3'd3;

  // Region codes picked by the template color.
  localparam logic [1:0] REGION_HEAD = 2'd0;
  localparam logic [1:0] REGION_BODY = 2'd1;
  localparam logic [1:0] REGION_LEGS = 2'd2;
  localparam logic [1:0] REGION_FEET = 2'd3;

  typedef logic [23:0] rgb_t;

  // Fixed palette, 0xRRGGBB per entry. Unused codes read as black.
  function automatic rgb_t palette(input logic [7:0] idx);
    rgb_t c;
    case (idx)
      8'd0:   c = 24'hFFFFFF;  8'd1:   c = 24'hFFD4BF;  8'd2:   c = 24'hFFE9BF;
      8'd3:   c = 24'hFFFFBF;  8'd4:   c = 24'hE9FFBF;  8'd5:   c = 24'hD4FFBF;
      8'd6:   c = 24'hBFFFBF;  8'd7:   c = 24'hBFFFD4;  8'd8:   c = 24'hBFFFE9;
      8'd9:   c = 24'hBFFFFF;  8'd10:  c = 24'hBFE9FF;  8'd11:  c = 24'hBFD4FF;
      8'd12:  c = 24'hBFBFFF;  8'd13:  c = 24'hD4BFFF;  8'd14:  c = 24'hE9BFFF;
      8'd15:  c = 24'hFFBFFF;  8'd16:  c = 24'hFFBFE9;  8'd17:  c = 24'hFFBFD4;
      8'd18:  c = 24'hFFBFBF;  8'd19:  c = 24'hDADADA;  8'd20:  c = 24'hBF9F8F;
      8'd21:  c = 24'hBFAF8F;  8'd22:  c = 24'hBFBF8F;  8'd23:  c = 24'hAFBF8F;
      8'd24:  c = 24'h9FBF8F;  8'd25:  c = 24'h8FBF8F;  8'd26:  c = 24'h8FBF9F;
      8'd27:  c = 24'h8FBFAF;  8'd28:  c = 24'h8FBFBF;  8'd29:  c = 24'h8FAFBF;
      8'd30:  c = 24'h8F9FBF;  8'd31:  c = 24'h8F8FBF;  8'd32:  c = 24'h9F8FBF;
      8'd33:  c = 24'hAF8FBF;  8'd34:  c = 24'hBF8FBF;  8'd35:  c = 24'hBF8FAF;
      8'd36:  c = 24'hBF8F9F;  8'd37:  c = 24'hBF8F8F;  8'd38:  c = 24'hB6B6B6;
      8'd39:  c = 24'hBF7F5F;  8'd40:  c = 24'hBFAF8F;  8'd41:  c = 24'hBFBF5F;
      8'd42:  c = 24'h9FBF5F;  8'd43:  c = 24'h7FBF5F;  8'd44:  c = 24'h5FBF5F;
      8'd45:  c = 24'h5FBF7F;  8'd46:  c = 24'h5FBF9F;  8'd47:  c = 24'h5FBFBF;
      8'd48:  c = 24'h5F9FBF;  8'd49:  c = 24'h5F7FBF;  8'd50:  c = 24'h5F5FBF;
      8'd51:  c = 24'h7F5FBF;  8'd52:  c = 24'h9F5FBF;  8'd53:  c = 24'hBF5FBF;
      8'd54:  c = 24'hBF5F9F;  8'd55:  c = 24'hBF5F7F;  8'd56:  c = 24'hBF5F5F;
      8'd57:  c = 24'h919191;  8'd58:  c = 24'hBF6A3F;  8'd59:  c = 24'hBF943F;
      8'd60:  c = 24'hBFBF3F;  8'd61:  c = 24'h94BF3F;  8'd62:  c = 24'h6ABF3F;
      8'd63:  c = 24'h3FBF3F;  8'd64:  c = 24'h3FBF6A;  8'd65:  c = 24'h3FBF94;
      8'd66:  c = 24'h3FBFBF;  8'd67:  c = 24'h3F94BF;  8'd68:  c = 24'h3F6ABF;
      8'd69:  c = 24'h3F3FBF;  8'd70:  c = 24'h6A3FBF;  8'd71:  c = 24'h943FBF;
      8'd72:  c = 24'hBF3FBF;  8'd73:  c = 24'hBF3F94;  8'd74:  c = 24'hBF3F6A;
      8'd75:  c = 24'hBF3F3F;  8'd76:  c = 24'h6D6D6D;  8'd77:  c = 24'hFF5500;
      8'd78:  c = 24'hFFAA00;  8'd79:  c = 24'hFFFF00;  8'd80:  c = 24'hAAFF00;
      8'd81:  c = 24'h54FF00;  8'd82:  c = 24'h00FF00;  8'd83:  c = 24'h00FF54;
      8'd84:  c = 24'h00FFAA;  8'd85:  c = 24'h00FFFF;  8'd86:  c = 24'h00A9FF;
      8'd87:  c = 24'h0055FF;  8'd88:  c = 24'h0000FF;  8'd89:  c = 24'h5500FF;
      8'd90:  c = 24'hA900FF;  8'd91:  c = 24'hFE00FF;  8'd92:  c = 24'hFF00AA;
      8'd93:  c = 24'hFF0055;  8'd94:  c = 24'hFF0000;  8'd95:  c = 24'h484848;
      8'd96:  c = 24'hBF3F00;  8'd97:  c = 24'hBF7F00;  8'd98:  c = 24'hBFBF00;
      8'd99:  c = 24'h7FBF00;  8'd100: c = 24'h3FBF00;  8'd101: c = 24'h00BF00;
      8'd102: c = 24'h00BF3F;  8'd103: c = 24'h00BF7F;  8'd104: c = 24'h00BFBF;
      8'd105: c = 24'h007FBF;  8'd106: c = 24'h003FBF;  8'd107: c = 24'h0000BF;
      8'd108: c = 24'h3F00BF;  8'd109: c = 24'h7F00BF;  8'd110: c = 24'hBF00BF;
      8'd111: c = 24'hBF007F;  8'd112: c = 24'hBF003F;  8'd113: c = 24'hBF0000;
      8'd114: c = 24'h242424;  8'd115: c = 24'h7F2A00;  8'd116: c = 24'h7F5500;
      8'd117: c = 24'h7F7F00;  8'd118: c = 24'h557F00;  8'd119: c = 24'h2A7F00;
      8'd120: c = 24'h007F00;  8'd121: c = 24'h007F2A;  8'd122: c = 24'h007F55;
      8'd123: c = 24'h007F7F;  8'd124: c = 24'h00547F;  8'd125: c = 24'h002A7F;
      8'd126: c = 24'h00007F;  8'd127: c = 24'h2A007F;  8'd128: c = 24'h54007F;
      8'd129: c = 24'h7F007F;  8'd130: c = 24'h7F0055;  8'd131: c = 24'h7F002A;
      8'd132: c = 24'h7F0000;
      default: c = 24'h000000;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/core/tpc_scale.sv
`timescale 1ns / 1ps

// Scales one 8-bit channel by an 8-bit palette channel: floor(base * coef / 255).
module tpc_scale (
  input  logic [7:0] base,
  input  logic [7:0] coef,
  output logic [7:0] scaled
);

  logic [15:0] prod;
  logic [15:0] sum;

  // The product never exceeds 255 * 255, so (p + (p >> 8) + 1) >> 8 is an exact
  // floor division by 255 and the sum stays inside 16 bits.
  assign prod   = 16'(base) * 16'(coef);
  assign sum    = prod + {8'd0, prod[15:8]} + 16'd1;
  assign scaled = sum[15:8];

endmodule

FILE: rtl/core/template_palette_colorizer.sv
`timescale 1ns / 1ps

// Channel   Ports                                        Handshake
// --------  -------------------------------------------  ----------------------------
// input     base_red..base_alpha, mask_red..mask_alpha   start high, busy low
// result    out_red, out_green, out_blue, out_alpha,     done high for one cycle
//           bad_mask
// config    wr_index, wr_data                            wr_en high
//
// One word is accepted every cycle; busy is always low.
// Each accepted word passes two registers: one input register, then the
// palette lookup, an 8x8 multiply and the divide-by-255 feed the result register.
// Reset clears the four palette indexes and the valid flags of both stages.
// The receiver cannot stall, so the pipeline never holds.
module template_palette_colorizer (
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] base_red,
  input  logic [7:0] base_green,
  input  logic [7:0] base_blue,
  input  logic [7:0] base_alpha,
  input  logic [7:0] mask_red,
  input  logic [7:0] mask_green,
  input  logic [7:0] mask_blue,
  input  logic [7:0] mask_alpha,
  input  logic       wr_en,
  input  logic [2:0] wr_index,
  input  logic [7:0] wr_data,
  output logic       done,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue,
  output logic [7:0] out_alpha,
  output logic       bad_mask
);

  logic [7:0] head_index;
  logic [7:0] body_index;
  logic [7:0] legs_index;
  logic [7:0] feet_index;

  logic       s1_valid;
  logic [7:0] s1_base_red;
  logic [7:0] s1_base_green;
  logic [7:0] s1_base_blue;
  logic [7:0] s1_base_alpha;
  logic [7:0] s1_mask_red;
  logic [7:0] s1_mask_green;
  logic [7:0] s1_mask_blue;
  logic [7:0] s1_mask_alpha;

  logic               disabled;
  logic               hit;
  logic [1:0]         region;
  logic [7:0]         sel;
  tpc_pkg::rgb_t      rgb;
  logic [7:0]         scaled_red;
  logic [7:0]         scaled_green;
  logic [7:0]         scaled_blue;

  assign busy = 1'b0;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      head_index <= 8'd0;
      body_index <= 8'd0;
      legs_index <= 8'd0;
      feet_index <= 8'd0;
    end else if (wr_en) begin
      case (wr_index)
        tpc_pkg::CFG_HEAD: head_index <= wr_data;
        tpc_pkg::CFG_BODY: body_index <= wr_data;
        tpc_pkg::CFG_LEGS: legs_index <= wr_data;
        tpc_pkg::CFG_FEET: feet_index <= wr_data;
        default: ;
      endcase
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      s1_base_red   <= base_red;
      s1_base_green <= base_green;
      s1_base_blue  <= base_blue;
      s1_base_alpha <= base_alpha;
      s1_mask_red   <= mask_red;
      s1_mask_green <= mask_green;
      s1_mask_blue  <= mask_blue;
      s1_mask_alpha <= mask_alpha;
    end
  end

  // Any index past the palette turns the whole block into a pass-through.
  assign disabled = (head_index >= 8'(tpc_pkg::PALETTE_ENTRIES))
                 || (body_index >= 8'(tpc_pkg::PALETTE_ENTRIES))
                 || (legs_index >= 8'(tpc_pkg::PALETTE_ENTRIES))
                 || (feet_index >= 8'(tpc_pkg::PALETTE_ENTRIES));

  // Decode the template color into a region.
  always_comb begin
    hit    = 1'b1;
    region = tpc_pkg::REGION_HEAD;
    if (s1_mask_red == 8'hFF && s1_mask_green == 8'hFF && s1_mask_blue == 8'h00) begin
      region = tpc_pkg::REGION_HEAD;
    end else if (s1_mask_red == 8'hFF && s1_mask_green == 8'h00
                 && s1_mask_blue == 8'h00) begin
      region = tpc_pkg::REGION_BODY;
    end else if (s1_mask_red == 8'h00 && s1_mask_green == 8'hFF
                 && s1_mask_blue == 8'h00) begin
      region = tpc_pkg::REGION_LEGS;
    end else if (s1_mask_red == 8'h00 && s1_mask_green == 8'h00
                 && s1_mask_blue == 8'hFF) begin
      region = tpc_pkg::REGION_FEET;
    end else begin
      hit = 1'b0;
    end
  end

  always_comb begin
    case (region)
      tpc_pkg::REGION_HEAD: sel = head_index;
      tpc_pkg::REGION_BODY: sel = body_index;
      tpc_pkg::REGION_LEGS: sel = legs_index;
      tpc_pkg::REGION_FEET: sel = feet_index;
      default:              sel = head_index;
    endcase
  end

  assign rgb = tpc_pkg::palette(sel);

  // One scaler per color channel.
  tpc_scale u_scale_red (
    .base   (s1_base_red),
    .coef   (rgb[23:16]),
    .scaled (scaled_red)
  );

  tpc_scale u_scale_green (
    .base   (s1_base_green),
    .coef   (rgb[15:8]),
    .scaled (scaled_green)
  );

  tpc_scale u_scale_blue (
    .base   (s1_base_blue),
    .coef   (rgb[7:0]),
    .scaled (scaled_blue)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid) begin
      if (!disabled && s1_mask_alpha != 8'd0 && hit) begin
        out_red   <= scaled_red;
        out_green <= scaled_green;
        out_blue  <= scaled_blue;
        out_alpha <= 8'hFF;
        bad_mask  <= 1'b0;
      end else begin
        out_red   <= s1_base_red;
        out_green <= s1_base_green;
        out_blue  <= s1_base_blue;
        out_alpha <= s1_base_alpha;
        bad_mask  <= !disabled && s1_mask_alpha != 8'd0 && !hit;
      end
    end
  end

  // Every accepted word yields exactly one result, through the input and result registers.
  a_latency: assert property (@(posedge clk) disable iff (rst)
    start |-> ##2 done)
    else $error("accepted word produced no result");

  // A strobe without a word in the input register is a phantom result.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    !s1_valid |=> !done)
    else $error("result strobe without a word in flight");

  // Out-of-range palette indexes never flag the template.
  a_disabled_clean: assert property (@(posedge clk) disable iff (rst)
    s1_valid && disabled |=> !bad_mask)
    else $error("bad_mask raised while colorizing is disabled");

  // A flagged pixel keeps the base alpha.
  a_bad_passthrough: assert property (@(posedge clk) disable iff (rst)
    s1_valid |=> !bad_mask || out_alpha == $past(s1_base_alpha))
    else $error("flagged pixel did not pass base alpha through");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int DRAIN_CYCLES = 4;
  localparam int STALL_LIMIT = 1000;
  localparam int SEGMENTS = 12;
  localparam int SEGMENT_PIXELS = 140;

  // Write index that maps to no register; writes to it must change nothing.
  localparam logic [2:0] CFG_SPARE = 3'd7;

  // Palette colors, 0xRRGGBB, in ROM order.
  localparam logic [23:0] PALETTE_RGB [133] = '{
    24'hFFFFFF, 24'hFFD4BF, 24'hFFE9BF, 24'hFFFFBF, 24'hE9FFBF, 24'hD4FFBF, 24'hBFFFBF,
    24'hBFFFD4, 24'hBFFFE9, 24'hBFFFFF, 24'hBFE9FF, 24'hBFD4FF, 24'hBFBFFF, 24'hD4BFFF,
    24'hE9BFFF, 24'hFFBFFF, 24'hFFBFE9, 24'hFFBFD4, 24'hFFBFBF, 24'hDADADA, 24'hBF9F8F,
    24'hBFAF8F, 24'hBFBF8F, 24'hAFBF8F, 24'h9FBF8F, 24'h8FBF8F, 24'h8FBF9F, 24'h8FBFAF,
    24'h8FBFBF, 24'h8FAFBF, 24'h8F9FBF, 24'h8F8FBF, 24'h9F8FBF, 24'hAF8FBF, 24'hBF8FBF,
    24'hBF8FAF, 24'hBF8F9F, 24'hBF8F8F, 24'hB6B6B6, 24'hBF7F5F, 24'hBFAF8F, 24'hBFBF5F,
    24'h9FBF5F, 24'h7FBF5F, 24'h5FBF5F, 24'h5FBF7F, 24'h5FBF9F, 24'h5FBFBF, 24'h5F9FBF,
    24'h5F7FBF, 24'h5F5FBF, 24'h7F5FBF, 24'h9F5FBF, 24'hBF5FBF, 24'hBF5F9F, 24'hBF5F7F,
    24'hBF5F5F, 24'h919191, 24'hBF6A3F, 24'hBF943F, 24'hBFBF3F, 24'h94BF3F, 24'h6ABF3F,
    24'h3FBF3F, 24'h3FBF6A, 24'h3FBF94, 24'h3FBFBF, 24'h3F94BF, 24'h3F6ABF, 24'h3F3FBF,
    24'h6A3FBF, 24'h943FBF, 24'hBF3FBF, 24'hBF3F94, 24'hBF3F6A, 24'hBF3F3F, 24'h6D6D6D,
    24'hFF5500, 24'hFFAA00, 24'hFFFF00, 24'hAAFF00, 24'h54FF00, 24'h00FF00, 24'h00FF54,
    24'h00FFAA, 24'h00FFFF, 24'h00A9FF, 24'h0055FF, 24'h0000FF, 24'h5500FF, 24'hA900FF,
    24'hFE00FF, 24'hFF00AA, 24'hFF0055, 24'hFF0000, 24'h484848, 24'hBF3F00, 24'hBF7F00,
    24'hBFBF00, 24'h7FBF00, 24'h3FBF00, 24'h00BF00, 24'h00BF3F, 24'h00BF7F, 24'h00BFBF,
    24'h007FBF, 24'h003FBF, 24'h0000BF, 24'h3F00BF, 24'h7F00BF, 24'hBF00BF, 24'hBF007F,
    24'hBF003F, 24'hBF0000, 24'h242424, 24'h7F2A00, 24'h7F5500, 24'h7F7F00, 24'h557F00,
    24'h2A7F00, 24'h007F00, 24'h007F2A, 24'h007F55, 24'h007F7F, 24'h00547F, 24'h002A7F,
    24'h00007F, 24'h2A007F, 24'h54007F, 24'h7F007F, 24'h7F0055, 24'h7F002A, 24'h7F0000
  };

  // Template colors that select each region, indexed by region code.
  localparam logic [23:0] REGION_COLOR [4] = '{24'hFFFF00, 24'hFF0000, 24'h00FF00, 24'h0000FF};

  typedef struct packed {
    logic [7:0] base_red;
    logic [7:0] base_green;
    logic [7:0] base_blue;
    logic [7:0] base_alpha;
    logic [7:0] mask_red;
    logic [7:0] mask_green;
    logic [7:0] mask_blue;
    logic [7:0] mask_alpha;
  } pixel_in_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       bad_mask;
  } pixel_out_t;

  // Holds the palette indexes and the recolored pixels still owed by the block.
  class pixel_scoreboard;
    logic [7:0] region_idx [4];
    pixel_out_t expected_pixels [$];
    int errors;

    function new();
      foreach (region_idx[i]) region_idx[i] = 8'd0;
      errors = 0;
    endfunction

    function void set_index(logic [2:0] idx, logic [7:0] value);
      case (idx)
        tpc_pkg::CFG_HEAD: region_idx[tpc_pkg::REGION_HEAD] = value;
        tpc_pkg::CFG_BODY: region_idx[tpc_pkg::REGION_BODY] = value;
        tpc_pkg::CFG_LEGS: region_idx[tpc_pkg::REGION_LEGS] = value;
        tpc_pkg::CFG_FEET: region_idx[tpc_pkg::REGION_FEET] = value;
        default: ;
      endcase
    endfunction

    // floor(base * c / 255) is exact in 16 bits and always fits back in 8.
    function logic [7:0] tint(logic [7:0] base, logic [7:0] c);
      logic [15:0] prod;
      prod = 16'(base) * 16'(c);
      return 8'(prod / 16'd255);
    endfunction

    function pixel_out_t recolor(pixel_in_t px);
      pixel_out_t res;
      logic [23:0] mask_rgb;
      logic [23:0] rgb;
      logic [7:0] sel;
      bit hit;
      bit disabled;
      res = '{px.base_red, px.base_green, px.base_blue, px.base_alpha, 1'b0};
      disabled = 1'b0;
      foreach (region_idx[i]) begin
        if (region_idx[i] >= tpc_pkg::PALETTE_ENTRIES) disabled = 1'b1;
      end
      if (disabled || px.mask_alpha == 8'h00) return res;
      mask_rgb = {px.mask_red, px.mask_green, px.mask_blue};
      hit = 1'b0;
      sel = 8'd0;
      foreach (REGION_COLOR[r]) begin
        if (!hit && mask_rgb == REGION_COLOR[r]) begin
          hit = 1'b1;
          sel = region_idx[r];
        end
      end
      if (!hit) begin
        res.bad_mask = 1'b1;
        return res;
      end
      rgb = PALETTE_RGB[sel];
      res.red = tint(px.base_red, rgb[23:16]);
      res.green = tint(px.base_green, rgb[15:8]);
      res.blue = tint(px.base_blue, rgb[7:0]);
      res.alpha = 8'hFF;
      return res;
    endfunction

    function void note_pixel(pixel_in_t px);
      expected_pixels = {expected_pixels, recolor(px)};
    endfunction

    function void compare_field(string name, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(pixel_out_t got);
      pixel_out_t want;
      if (expected_pixels.size() == 0) begin
        $display("%0t: unexpected result word %0h", $time, got);
        errors++;
        return;
      end
      want = expected_pixels.pop_front();
      compare_field("out_red", want.red, got.red);
      compare_field("out_green", want.green, got.green);
      compare_field("out_blue", want.blue, got.blue);
      compare_field("out_alpha", want.alpha, got.alpha);
      compare_field("bad_mask", 8'(want.bad_mask), 8'(got.bad_mask));
    endfunction

    function int pending();
      return expected_pixels.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  pixel_in_t pix_in = '0;
  logic wr_en = 1'b0;
  logic [2:0] wr_index = tpc_pkg::CFG_HEAD;
  logic [7:0] wr_data = 8'd0;
  logic done;
  pixel_out_t pix_out;

  pixel_scoreboard sb = new();
  int idle_pct = 0;
  int stall_cycles = 0;

  always #5 clk = ~clk;

  template_palette_colorizer i_dut (
    .clk        (clk),
    .rst        (rst),
    .start      (start),
    .busy       (busy),
    .base_red   (pix_in.base_red),
    .base_green (pix_in.base_green),
    .base_blue  (pix_in.base_blue),
    .base_alpha (pix_in.base_alpha),
    .mask_red   (pix_in.mask_red),
    .mask_green (pix_in.mask_green),
    .mask_blue  (pix_in.mask_blue),
    .mask_alpha (pix_in.mask_alpha),
    .wr_en      (wr_en),
    .wr_index   (wr_index),
    .wr_data    (wr_data),
    .done       (done),
    .out_red    (pix_out.red),
    .out_green  (pix_out.green),
    .out_blue   (pix_out.blue),
    .out_alpha  (pix_out.alpha),
    .bad_mask   (pix_out.bad_mask)
  );

  // Every strobed result word is checked against the oldest prediction.
  always @(posedge clk) begin
    if (!rst && done !== 1'b0) sb.check_result(pix_out);
  end

  // The run is stuck if nothing moves on any port for too long.
  always @(posedge clk) begin
    if ((start && !busy) || done || wr_en) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  // Offer one pixel word, with random sender gaps ahead of it.
  task automatic send_pixel(input pixel_in_t px);
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start <= 1'b1;
    pix_in <= px;
    @(posedge clk);
    while (busy) @(posedge clk);
    sb.note_pixel(px);
  endtask

  // Wait until every predicted word has come out and the pipeline is empty.
  task automatic wait_drained();
    start <= 1'b0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
    wait_drained();
    wr_en <= 1'b1;
    wr_index <= idx;
    wr_data <= value;
    @(posedge clk);
    sb.set_index(idx, value);
    wr_en <= 1'b0;
  endtask

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'h00;
      1: return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Mostly region colors, some near misses with one bit flipped, the rest random.
  function automatic pixel_in_t rand_pixel();
    pixel_in_t px;
    logic [23:0] mask_rgb;
    int kind;
    kind = $urandom_range(9);
    if (kind <= 6) begin
      mask_rgb = REGION_COLOR[$urandom_range(3)];
      if (kind == 6) mask_rgb[$urandom_range(23)] ^= 1'b1;
    end else begin
      mask_rgb = 24'($urandom());
    end
    px.base_red = rand_channel();
    px.base_green = rand_channel();
    px.base_blue = rand_channel();
    px.base_alpha = rand_channel();
    {px.mask_red, px.mask_green, px.mask_blue} = mask_rgb;
    px.mask_alpha = ($urandom_range(4) == 0) ? 8'h00 : rand_channel();
    return px;
  endfunction

  function automatic logic [7:0] rand_index();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'(tpc_pkg::PALETTE_ENTRIES - 1);
      default: return 8'($urandom_range(tpc_pkg::PALETTE_ENTRIES - 1));
    endcase
  endfunction

  initial begin
    logic [7:0] idx_val [4];
    int off_reg;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset indexes select white, so colorized pixels keep their color.
    send_pixel(pixel_in_t'({32'hFFFFFFFF, 32'hFFFF00FF}));
    send_pixel(pixel_in_t'({32'h12345600, 32'hFF000001}));

    // Each region gets a distinct color, with the last palette entry on head.
    write_reg(tpc_pkg::CFG_HEAD, 8'd132);
    write_reg(tpc_pkg::CFG_BODY, 8'd94);
    write_reg(tpc_pkg::CFG_LEGS, 8'd82);
    write_reg(tpc_pkg::CFG_FEET, 8'd88);
    send_pixel(pixel_in_t'({32'hFFFFFFFF, 32'hFFFF00FF}));
    send_pixel(pixel_in_t'({32'hFFFFFFFF, 32'hFF0000FF}));
    send_pixel(pixel_in_t'({32'hFFFFFFFF, 32'h00FF0080}));
    send_pixel(pixel_in_t'({32'hFFFFFFFF, 32'h0000FF01}));
    send_pixel(pixel_in_t'({32'h00000000, 32'hFFFF00FF}));
    send_pixel(pixel_in_t'({32'h80C040FF, 32'h0000FFFF}));
    // Transparent template, then opaque colors that match no region, then a transparent black one.
    send_pixel(pixel_in_t'({32'hA5A5A5A5, 32'hFF000000}));
    send_pixel(pixel_in_t'({32'h5A5A5A5A, 32'hFFFFFFFF}));
    send_pixel(pixel_in_t'({32'h5A5A5A5A, 32'h000000FF}));
    send_pixel(pixel_in_t'({32'h5A5A5A5A, 32'hFEFF00FF}));
    send_pixel(pixel_in_t'({32'h5A5A5A5A, 32'hFF0001FF}));
    send_pixel(pixel_in_t'({32'h5A5A5A5A, 32'h00000000}));

    // A write to an unmapped index must leave colorizing enabled.
    write_reg(CFG_SPARE, 8'hFF);
    send_pixel(pixel_in_t'({32'h7F7F7F7F, 32'hFF0000FF}));

    // One index just out of range turns every pixel into a pass-through.
    write_reg(tpc_pkg::CFG_FEET, 8'(tpc_pkg::PALETTE_ENTRIES));
    send_pixel(pixel_in_t'({32'h3C3C3C3C, 32'hFFFF00FF}));
    send_pixel(pixel_in_t'({32'h3C3C3C3C, 32'h123456FF}));
    send_pixel(pixel_in_t'({32'h3C3C3C3C, 32'h0000FFFF}));
    write_reg(tpc_pkg::CFG_FEET, 8'd88);
    write_reg(tpc_pkg::CFG_LEGS, 8'hFF);
    send_pixel(pixel_in_t'({32'hC3C3C3C3, 32'h00FF00FF}));
    write_reg(tpc_pkg::CFG_LEGS, 8'd82);
    send_pixel(pixel_in_t'({32'hC3C3C3C3, 32'h00FF00FF}));

    // Random segments, each under a new set of indexes.
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      idle_pct = (seg < SEGMENTS / 3) ? 26 : (seg < 2 * SEGMENTS / 3) ? 57 : 0;
      foreach (idx_val[r]) idx_val[r] = rand_index();
      if (seg % 4 == 3) begin
        off_reg = $urandom_range(3);
        idx_val[off_reg] = 8'($urandom_range(255, tpc_pkg::PALETTE_ENTRIES));
      end
      write_reg(tpc_pkg::CFG_HEAD, idx_val[tpc_pkg::REGION_HEAD]);
      write_reg(tpc_pkg::CFG_BODY, idx_val[tpc_pkg::REGION_BODY]);
      write_reg(tpc_pkg::CFG_LEGS, idx_val[tpc_pkg::REGION_LEGS]);
      write_reg(tpc_pkg::CFG_FEET, idx_val[tpc_pkg::REGION_FEET]);
      for (int n = 0; n < SEGMENT_PIXELS; n++) send_pixel(rand_pixel());
    end

    wait_drained();
    if (sb.errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
